### src/adpcm_pkg.sv
// adpcm_pkg: shared types, constants and filter coefficient tables for the
// adpcm block decoder. No dependencies; used by every module under src.
`default_nettype none

package adpcm_pkg;

  localparam int unsigned SamplesPerBlock = 28;
  localparam int unsigned IdxW = 5;
  localparam int unsigned AccW = 25;
  localparam int unsigned CoefW = 8;

  localparam logic [3:0] PosHeader = 4'd0;
  localparam logic [3:0] PosFlags = 4'd1;
  localparam logic [3:0] PosFirstData = 4'd2;
  localparam logic [IdxW-1:0] LastSampleIdx = IdxW'(SamplesPerBlock - 1);

  localparam int unsigned FlagLoopEnd = 0;
  localparam int unsigned FlagLoopStart = 2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL_A  = 4'b0010,
    ST_MUL_B  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic load;
    logic accumulate;
  } mac_op_t;

  function automatic logic signed [CoefW-1:0] coef_a(input logic [3:0] sel);
    logic signed [CoefW-1:0] c;
    case (sel)
      4'd1:    c = 8'sd60;
      4'd2:    c = 8'sd115;
      4'd3:    c = 8'sd98;
      4'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] coef_b(input logic [3:0] sel);
    logic signed [CoefW-1:0] c;
    case (sel)
      4'd2:    c = -8'sd52;
      4'd3:    c = -8'sd55;
      4'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### src/adpcm_mac.sv
// adpcm_mac: shared signed multiply-accumulate unit, one product per cycle.
// Depends on adpcm_pkg for widths and the mac_op_t control struct.
`default_nettype none

module adpcm_mac (
  input  wire logic                                    clk,
  input  wire adpcm_pkg::mac_op_t                      op,
  input  wire logic signed [15:0]                      hist,
  input  wire logic signed [adpcm_pkg::CoefW-1:0]      coef,
  output logic signed [adpcm_pkg::AccW-1:0]            acc
);

  logic signed [15+adpcm_pkg::CoefW:0] product;
  logic signed [adpcm_pkg::AccW-1:0]   product_ext;

  assign product = hist * coef;
  assign product_ext = adpcm_pkg::AccW'(product);

  always_ff @(posedge clk) begin
    if (op.load) begin
      acc <= product_ext;
    end else if (op.accumulate) begin
      acc <= acc + product_ext;
    end
  end

endmodule

`default_nettype wire

### src/adpcm_sample.sv
// adpcm_sample: scales a nibble by the block shift, adds the prediction and
// saturates to 16 bits. Combinational; depends on adpcm_pkg for widths.
`default_nettype none

module adpcm_sample (
  input  wire logic [3:0]                         nibble,
  input  wire logic [3:0]                         shift,
  input  wire logic signed [adpcm_pkg::AccW-1:0]  acc,
  output logic signed [15:0]                      sample
);

  logic signed [15:0]                  nib_term;
  logic signed [adpcm_pkg::AccW-7:0]   pred;
  logic signed [19:0]                  sum;

  always_comb begin
    nib_term = $signed({nibble, 12'h000}) >>> shift;
    // dropping the low six bits gives the floor of the prediction
    pred = $signed(acc[adpcm_pkg::AccW-1:6]);
    sum = 20'(nib_term) + 20'(pred);
    if (sum > 20'sd32767) begin
      sample = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      sample = -16'sh8000;
    end else begin
      sample = sum[15:0];
    end
  end

endmodule

`default_nettype wire

### src/adpcm_block_decoder.sv
// adpcm_block_decoder: top level with the byte sequencer, filter history and
// output register. Depends on adpcm_pkg, adpcm_mac and adpcm_sample.
`default_nettype none

// Takes a 16-byte block one byte per request: a header byte (filter, shift),
// a flag byte (loop start, loop end) and 14 data bytes that each give two
// samples, low nibble first. Header and flag bytes leave the input ready for
// the next byte and give no output. A data byte keeps the input stalled after
// its request until both nibbles are done: each nibble passes ST_MUL_A and
// ST_MUL_B in the single shared multiplier (newest and older history terms),
// then ST_FINISH to scale, add and saturate, where it waits on m_axis_tready
// while the output register is full. The filter history carries across blocks; block_done travels
// as m_axis_tlast.
module adpcm_block_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [23:8] block_addr
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] sample, [20:16] sample_index, [21] last_of_byte, [22] jump_taken,
  // [38:23] jump_addr, [39] zero
  output logic [39:0]      m_axis_tdata,
  // block_done
  output logic             m_axis_tlast
);

  adpcm_pkg::state_t state;
  logic [3:0]  byte_position;
  logic [3:0]  cur_pos;
  logic [7:0]  cur_byte;
  logic        half;
  logic [3:0]  filter_select;
  logic [3:0]  shift_amount;
  logic        end_flag;
  logic [15:0] history_newest;
  logic [15:0] history_older;
  logic [15:0] repeat_address;

  logic [15:0]                    out_sample;
  logic [adpcm_pkg::IdxW-1:0]     out_index;
  logic                           out_last_of_byte;
  logic                           out_done;
  logic                           out_jump;
  logic [15:0]                    out_jump_addr;

  adpcm_pkg::mac_op_t                     mac_op;
  logic signed [15:0]                     mac_hist;
  logic signed [adpcm_pkg::CoefW-1:0]     mac_coef;
  logic signed [adpcm_pkg::AccW-1:0]      acc;
  logic [3:0]                             nibble;
  logic signed [15:0]                     new_sample;
  logic [3:0]                             pos_m2;
  logic [adpcm_pkg::IdxW-1:0]             sample_idx;
  logic                                   idx_done;
  logic                                   out_free;
  logic                                   in_req;
  logic [7:0]                             in_byte;
  logic [15:0]                            in_addr;

  assign in_byte = s_axis_tdata[7:0];
  assign in_addr = s_axis_tdata[23:8];
  assign s_axis_tready = (state == adpcm_pkg::ST_IDLE);
  assign in_req = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    mac_op = '0;
    mac_hist = $signed(history_newest);
    mac_coef = adpcm_pkg::coef_a(filter_select);
    if (state == adpcm_pkg::ST_MUL_A) begin
      mac_op.load = 1'b1;
    end else if (state == adpcm_pkg::ST_MUL_B) begin
      mac_op.accumulate = 1'b1;
      mac_hist = $signed(history_older);
      mac_coef = adpcm_pkg::coef_b(filter_select);
    end
  end

  adpcm_mac u_mac (
    .clk  (clk),
    .op   (mac_op),
    .hist (mac_hist),
    .coef (mac_coef),
    .acc  (acc)
  );

  assign nibble = half ? cur_byte[7:4] : cur_byte[3:0];

  adpcm_sample u_sample (
    .nibble (nibble),
    .shift  (shift_amount),
    .acc    (acc),
    .sample (new_sample)
  );

  assign pos_m2 = cur_pos - adpcm_pkg::PosFirstData;
  assign sample_idx = {pos_m2, half};
  assign idx_done = (sample_idx == adpcm_pkg::LastSampleIdx);

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adpcm_pkg::ST_IDLE;
      byte_position <= '0;
      filter_select <= '0;
      shift_amount <= '0;
      end_flag <= 1'b0;
      history_newest <= '0;
      history_older <= '0;
      repeat_address <= 16'd512;
      half <= 1'b0;
    end else begin
      unique case (state)
        adpcm_pkg::ST_IDLE: begin
          if (in_req) begin
            byte_position <= byte_position + 4'd1;
            if (byte_position == adpcm_pkg::PosHeader) begin
              filter_select <= in_byte[7:4];
              shift_amount <= in_byte[3:0];
            end else if (byte_position == adpcm_pkg::PosFlags) begin
              if (in_byte[adpcm_pkg::FlagLoopStart]) begin
                repeat_address <= in_addr;
              end
              end_flag <= in_byte[adpcm_pkg::FlagLoopEnd];
            end else begin
              half <= 1'b0;
              state <= adpcm_pkg::ST_MUL_A;
            end
          end
        end
        adpcm_pkg::ST_MUL_A: begin
          state <= adpcm_pkg::ST_MUL_B;
        end
        adpcm_pkg::ST_MUL_B: begin
          state <= adpcm_pkg::ST_FINISH;
        end
        adpcm_pkg::ST_FINISH: begin
          // hold here until the output register can take the sample
          if (out_free) begin
            history_older <= history_newest;
            history_newest <= new_sample;
            half <= 1'b1;
            state <= half ? adpcm_pkg::ST_IDLE : adpcm_pkg::ST_MUL_A;
          end
        end
        default: state <= adpcm_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      cur_byte <= in_byte;
      cur_pos <= byte_position;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == adpcm_pkg::ST_FINISH && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == adpcm_pkg::ST_FINISH && out_free) begin
      out_sample <= new_sample;
      out_index <= sample_idx;
      out_last_of_byte <= half;
      out_done <= idx_done;
      out_jump <= idx_done && end_flag;
      out_jump_addr <= (idx_done && end_flag) ? repeat_address : 16'd0;
    end
  end

  assign m_axis_tdata = {1'b0, out_jump_addr, out_jump, out_last_of_byte, out_index, out_sample};
  assign m_axis_tlast = out_done;

endmodule

`default_nettype wire

### verif/tb.sv
// tb: self-checking bench for adpcm_block_decoder, block streams in, checked samples out.
// Depends on adpcm_pkg for the block layout and flag bit positions, and on the decoder RTL.
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [4:0]         index;
    logic               second_nibble;
    logic               block_end;
    logic               jump;
    logic [15:0]        jump_target;
  } pcm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  adpcm_block_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // stream bytes waiting to be requested, each {block_addr, data_byte}
  logic [23:0] byte_stream[$];
  pcm_result_t pending_samples[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned samples_seen = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  logic        byte_taken = 1'b0;

  // decoder state as predicted
  logic [3:0]         blk_pos = '0;
  logic [3:0]         blk_filter = '0;
  logic [3:0]         blk_shift = '0;
  logic               blk_loop_end = 1'b0;
  logic signed [15:0] hist_new = '0;
  logic signed [15:0] hist_old = '0;
  logic [15:0]        loop_addr = 16'd512;

  function automatic int filter_prediction(logic [3:0] f, int h0, int h1);
    int acc;
    case (f)
      4'd1:    acc = h0 * 60;
      4'd2:    acc = h0 * 115 - h1 * 52;
      4'd3:    acc = h0 * 98 - h1 * 55;
      4'd4:    acc = h0 * 122 - h1 * 60;
      default: acc = 0;
    endcase
    return acc >>> 6;
  endfunction

  task automatic decode_byte(input logic [23:0] word);
    logic [7:0]  b;
    logic [3:0]  pos;
    int          nv;
    int          s;
    int          k;
    pcm_result_t r;
    b = word[7:0];
    pos = blk_pos;
    blk_pos = blk_pos + 4'd1;
    if (pos == adpcm_pkg::PosHeader) begin
      blk_filter = b[7:4];
      blk_shift = b[3:0];
    end else if (pos == adpcm_pkg::PosFlags) begin
      if (b[adpcm_pkg::FlagLoopStart]) loop_addr = word[23:8];
      blk_loop_end = b[adpcm_pkg::FlagLoopEnd];
    end else begin
      for (k = 0; k < 2; k++) begin
        nv = k ? b[7:4] : b[3:0];
        if (nv > 7) nv -= 16;
        s = ((nv * 4096) >>> blk_shift) + filter_prediction(blk_filter, hist_new, hist_old);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        hist_old = hist_new;
        hist_new = s[15:0];
        r.sample = s[15:0];
        r.index = 5'((pos - 2) * 2 + k);
        r.second_nibble = (k == 1);
        r.block_end = (r.index == 5'(adpcm_pkg::SamplesPerBlock - 1));
        r.jump = r.block_end && blk_loop_end;
        r.jump_target = r.jump ? loop_addr : 16'd0;
        pending_samples.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: requests into the predictor, samples against the oldest prediction
  always @(posedge clk) begin
    pcm_result_t want;
    byte_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (byte_taken) decode_byte(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        check_field("sample", want.sample, $signed(m_axis_tdata[15:0]));
        check_field("sample_index", want.index, m_axis_tdata[20:16]);
        check_field("last_of_byte", want.second_nibble, m_axis_tdata[21]);
        check_field("jump_taken", want.jump, m_axis_tdata[22]);
        check_field("jump_addr", want.jump_target, m_axis_tdata[38:23]);
        check_field("block_done", want.block_end, m_axis_tlast);
      end
    end
  end

  // driver: holds a request until taken, otherwise offers the next byte or goes idle
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !byte_taken)) begin
      if (byte_stream.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata <= byte_stream.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus a long hold when one is requested
  always @(negedge clk) begin
    if (hold_served != hold_req) begin
      hold_served = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[adpcm_block_decoder] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] rand_header();
    logic [3:0] f;
    logic [3:0] sh;
    f = ($urandom_range(0, 99) < 75) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
    sh = ($urandom_range(0, 99) < 25) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
    return {f, sh};
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 19))
      0:       return 8'h77;
      1:       return 8'h88;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one block: given header and flags, random data bytes and addresses
  task automatic push_block(input logic [7:0] hdr, input logic [7:0] flg,
                            input logic [15:0] addr);
    int i;
    byte_stream.push_back({16'($urandom_range(0, 65535)), hdr});
    byte_stream.push_back({addr, flg});
    for (i = 0; i < 14; i++) byte_stream.push_back({16'($urandom_range(0, 65535)), rand_data()});
  endtask

  task automatic push_random_blocks(input int n);
    int i;
    for (i = 0; i < n; i++)
      push_block(rand_header(), 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_drained();
    while (byte_stream.size() != 0 || s_axis_tvalid || pending_samples.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 1: slow receiver
    send_idle_pct = 15;
    recv_idle_pct = 83;
    // filter 4, no shift, loop start and end at the top address: drives saturation both ways
    byte_stream.push_back({16'h0000, 8'h40});
    byte_stream.push_back({16'hFFFF, 8'h05});
    byte_stream.push_back({16'h0000, 8'h77});
    byte_stream.push_back({16'hFFFF, 8'h77});
    byte_stream.push_back({16'h0000, 8'h77});
    byte_stream.push_back({16'hFFFF, 8'h77});
    byte_stream.push_back({16'h0000, 8'h88});
    byte_stream.push_back({16'hFFFF, 8'h88});
    byte_stream.push_back({16'h0000, 8'h88});
    byte_stream.push_back({16'hFFFF, 8'h88});
    byte_stream.push_back({16'h0000, 8'h0F});
    byte_stream.push_back({16'hFFFF, 8'hF0});
    byte_stream.push_back({16'h0000, 8'h00});
    byte_stream.push_back({16'hFFFF, 8'hFF});
    byte_stream.push_back({16'h0000, 8'h7F});
    byte_stream.push_back({16'hFFFF, 8'hF8});
    // unknown filter with the largest shift; flag byte with only ignored bits set
    push_block(8'hFF, 8'hFA, 16'h0000);
    push_block(8'h1D, 8'h01, 16'h1234);
    push_random_blocks(32);
    while (samples_seen < 20) @(posedge clk);
    hold_req++;
    wait_drained();

    // phase 2: slow sender
    send_idle_pct = 83;
    recv_idle_pct = 15;
    push_random_blocks(35);
    wait_drained();

    // phase 3: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_blocks(30);
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("[adpcm_block_decoder] OK");
    end else begin
      $display("[adpcm_block_decoder] ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/adpcm_pkg.sv
src/adpcm_mac.sv
src/adpcm_sample.sv
src/adpcm_block_decoder.sv
verif/tb.sv
